// ===== hw/rtl/mde_pkg.sv =====
// ----------------------------------------------------------------------------
// mde_pkg
// Types and codes shared by the distance estimator modules.
// ----------------------------------------------------------------------------
package mde_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS_SQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RADIUS_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT_SQ      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 3'd5;

    // multiplier second operand
    localparam logic [1:0] MUL_B_SQ    = 2'd0;
    localparam logic [1:0] MUL_B_F     = 2'd1;
    localparam logic [1:0] MUL_B_SCALE = 2'd2;

    // divider use
    localparam logic DIV_SEL_FOLD = 1'b0;
    localparam logic DIV_SEL_DIST = 1'b1;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } mde_in_t;

    typedef struct packed {
        logic        [30:0] distance;
        logic signed [31:0] trap_x;
        logic signed [31:0] trap_y;
        logic signed [31:0] trap_z;
        logic signed [63:0] trap_w;
    } mde_out_t;

    typedef struct packed {
        logic signed [24:0] fold_scale;
        logic        [23:0] min_radius_sq;
        logic        [23:0] fixed_radius_sq;
        logic        [23:0] box_limit;
        logic        [30:0] bailout_sq;
        logic        [4:0]  iteration_count;
    } mde_cfg_t;

    typedef struct packed {
        logic       load;
        logic       fold;
        logic       acc_clr;
        logic       mul_start;
        logic [1:0] mul_k;
        logic [1:0] mul_b;
        logic       div_start;
        logic       div_sel;
        logic       trap_upd;
        logic       sqrt_start;
        logic       out_load;
    } mde_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic bail;
        logic w3_zero;
    } mde_sts_t;

endpackage

// ===== hw/rtl/mde_mul.sv =====
// ----------------------------------------------------------------------------
// mde_mul
// Sequential 64x64 unsigned multiplier built on one 32x32 multiplier.
// Four partial products, or one when both high words are zero.
// ----------------------------------------------------------------------------
module mde_mul
    import mde_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [63:0]   op_a,
    input  logic [63:0]   op_b,
    output logic          done,
    output logic [127:0]  prod
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   step_reg, pp_step_reg;
    logic         run_reg, full_reg, pp_vld_reg, pp_last_reg, done_reg;
    logic [31:0]  a_sel, b_sel;
    logic         last_issue;
    logic [127:0] pp_shifted;

    always_comb begin
        a_sel = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_sel = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        last_issue = (step_reg == 2'd3) || !full_reg;
        case (pp_step_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            pp_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg   <= pp_vld_reg && pp_last_reg;
            pp_vld_reg <= run_reg;
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && last_issue) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= op_a;
            b_reg    <= op_b;
            full_reg <= (op_a[63:32] != 32'd0) || (op_b[63:32] != 32'd0);
            step_reg <= 2'd0;
            acc_reg  <= '0;
        end else begin
            if (run_reg) begin
                pp_reg      <= 64'(a_sel * b_sel);
                pp_step_reg <= step_reg;
                pp_last_reg <= last_issue;
                step_reg    <= step_reg + 2'd1;
            end
            if (pp_vld_reg) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/mde_div.sv =====
// ----------------------------------------------------------------------------
// mde_div
// Restoring radix-2 unsigned divider, 64 by 64 bits, one quotient bit
// per cycle. The divisor is never zero when started.
// ----------------------------------------------------------------------------
module mde_div
    import mde_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    localparam int W     = 64;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     num_reg, den_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg, done_reg;
    logic [W:0]       sh, diff;
    logic             ge;

    always_comb begin
        sh   = {rem_reg, num_reg[W-1]};
        diff = sh - {1'b0, den_reg};
        ge   = (sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(W - 1));
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && (cnt_reg == CNT_W'(W - 1))) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (run_reg) begin
            // quotient bits shift in behind the dividend
            rem_reg <= ge ? diff[W-1:0] : sh[W-1:0];
            num_reg <= {num_reg[W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// ===== hw/rtl/mde_sqrt.sv =====
// ----------------------------------------------------------------------------
// mde_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mde_sqrt
    import mde_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] n_reg, res_reg, bit_reg, trial;
    logic        run_reg, done_reg;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (bit_reg == 64'd1);
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && (bit_reg == 64'd1)) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= rad;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (run_reg) begin
            if (n_reg >= trial) begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== hw/rtl/mde_datapath.sv =====
// ----------------------------------------------------------------------------
// mde_datapath
// Orbit registers, fold logic, trap and result register, with the shared
// multiplier and divider and the square root unit.
// ----------------------------------------------------------------------------
module mde_datapath
    import mde_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  mde_cfg_t cfg,
    input  mde_in_t  in_data,
    input  mde_cmd_t cmd,
    output mde_sts_t sts,
    output mde_out_t out_data
);

    localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    logic signed [31:0] w_reg   [3];
    logic signed [31:0] w0_reg  [3];
    logic signed [31:0] trap_reg[3];
    logic signed [63:0] w3_reg, trap3_reg;
    logic [63:0]        acc_reg, f_reg;
    logic [31:0]        root_reg;
    logic [30:0]        dist_reg;
    logic [1:0]         k_reg, b_reg;
    logic               neg_reg, div_sel_reg;
    mde_out_t           out_reg;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // ---- operand selection ----
    logic signed [63:0] a_signed, scale64;
    logic [63:0]        mul_a, mul_b, div_num, div_den;
    logic               mul_neg;

    always_comb begin
        a_signed = (cmd.mul_k == 2'd3) ? w3_reg
                                       : 64'(w_reg[cmd.mul_k[1:0] == 2'd3 ? 2'd0 : cmd.mul_k]);
        scale64  = 64'(cfg.fold_scale);
        mul_a    = mag64(a_signed);
        case (cmd.mul_b)
            MUL_B_F:     mul_b = f_reg;
            MUL_B_SCALE: mul_b = mag64(scale64);
            default:     mul_b = mul_a;
        endcase
        mul_neg = a_signed[63] ^ ((cmd.mul_b == MUL_B_SCALE) && scale64[63]);
    end

    // ---- sphere fold radius and divider operands ----
    logic [63:0] d_sh, d_lo, d_cl;

    always_comb begin
        d_sh = acc_reg >> FRAC_BITS;
        d_lo = (d_sh < 64'(cfg.min_radius_sq)) ? 64'(cfg.min_radius_sq) : d_sh;
        d_cl = (d_lo > 64'(cfg.fixed_radius_sq)) ? 64'(cfg.fixed_radius_sq) : d_lo;
        if (d_cl == 64'd0) begin
            d_cl = 64'd1;
        end
        if (cmd.div_sel == DIV_SEL_DIST) begin
            div_num = 64'(root_reg) << FRAC_BITS;
            div_den = mag64(w3_reg);
        end else begin
            div_num = 64'(cfg.fixed_radius_sq) << FRAC_BITS;
            div_den = d_cl;
        end
    end

    // ---- units ----
    logic         mul_done, div_done, sqrt_done;
    logic [127:0] prod;
    logic [63:0]  quo;
    logic [31:0]  root;

    mde_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (prod)
    );

    mde_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    mde_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .rad     (acc_reg),
        .done    (sqrt_done),
        .root    (root)
    );

    // ---- product shift and saturation ----
    logic [63:0]        rl, pmag;
    logic               hi_nz;
    logic signed [63:0] ms;
    logic signed [64:0] w3_sum;
    logic signed [65:0] wk_sum;
    logic signed [31:0] wk_scaled, wk_f, w0_k;
    logic signed [63:0] w3_scaled;

    always_comb begin
        rl    = prod[FRAC_BITS +: 64];
        hi_nz = |prod[127:FRAC_BITS+64];
        pmag  = hi_nz ? '1 : rl;
        if (neg_reg) begin
            ms = pmag[63] ? S64_MIN : (64'sd0 - $signed(pmag));
        end else begin
            ms = pmag[63] ? S64_MAX : $signed(pmag);
        end
        w0_k      = w0_reg[k_reg == 2'd3 ? 2'd0 : k_reg];
        wk_f      = sat32(66'(ms));
        wk_sum    = 66'(ms) + 66'(w0_k);
        wk_scaled = sat32(wk_sum);
        w3_sum    = 65'(ms) + 65'(ONE);
        if (w3_sum > 65'(S64_MAX)) begin
            w3_scaled = S64_MAX;
        end else if (w3_sum < 65'(S64_MIN)) begin
            w3_scaled = S64_MIN;
        end else begin
            w3_scaled = w3_sum[63:0];
        end
    end

    // ---- box fold ----
    logic signed [31:0] fold_w[3];

    always_comb begin
        logic signed [32:0] lim, w33, c;
        logic signed [34:0] t;
        lim = $signed({9'd0, cfg.box_limit});
        for (int i = 0; i < 3; i++) begin
            w33 = 33'(w_reg[i]);
            c   = w33;
            if (c > lim) begin
                c = lim;
            end
            if (c < -lim) begin
                c = -lim;
            end
            t = (35'(c) <<< 1) - 35'(w33);
            fold_w[i] = sat32(66'(t));
        end
    end

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            k_reg   <= cmd.mul_k;
            b_reg   <= cmd.mul_b;
            neg_reg <= mul_neg;
        end
        if (cmd.div_start) begin
            div_sel_reg <= cmd.div_sel;
        end

        if (cmd.load) begin
            w_reg[0]    <= in_data.pos_x;
            w_reg[1]    <= in_data.pos_y;
            w_reg[2]    <= in_data.pos_z;
            w0_reg[0]   <= in_data.pos_x;
            w0_reg[1]   <= in_data.pos_y;
            w0_reg[2]   <= in_data.pos_z;
            trap_reg[0] <= in_data.pos_x;
            trap_reg[1] <= in_data.pos_y;
            trap_reg[2] <= in_data.pos_z;
            w3_reg      <= ONE;
            trap3_reg   <= ONE;
        end

        if (cmd.fold) begin
            for (int i = 0; i < 3; i++) begin
                w_reg[i] <= fold_w[i];
            end
        end

        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end

        if (cmd.trap_upd) begin
            for (int i = 0; i < 3; i++) begin
                if (w_reg[i] < trap_reg[i]) begin
                    trap_reg[i] <= w_reg[i];
                end
            end
            if (w3_reg < trap3_reg) begin
                trap3_reg <= w3_reg;
            end
        end

        // write back a finished product
        if (mul_done) begin
            case (b_reg)
                MUL_B_F: begin
                    if (k_reg == 2'd3) begin
                        w3_reg <= ms;
                    end else begin
                        w_reg[k_reg] <= wk_f;
                    end
                end
                MUL_B_SCALE: begin
                    if (k_reg == 2'd3) begin
                        w3_reg <= w3_scaled;
                    end else begin
                        w_reg[k_reg] <= wk_scaled;
                    end
                end
                default: acc_reg <= acc_reg + prod[63:0];
            endcase
        end

        if (div_done) begin
            if (div_sel_reg == DIV_SEL_DIST) begin
                dist_reg <= (quo[63:33] != 31'd0) ? DIST_MAX : quo[32:2];
            end else begin
                f_reg <= quo;
            end
        end

        if (sqrt_done) begin
            root_reg <= root;
        end

        if (cmd.out_load) begin
            out_reg.distance <= (w3_reg == 64'sd0) ? DIST_MAX : dist_reg;
            out_reg.trap_x   <= trap_reg[0];
            out_reg.trap_y   <= trap_reg[1];
            out_reg.trap_z   <= trap_reg[2];
            out_reg.trap_w   <= trap3_reg;
        end
    end

    always_comb begin
        sts.mul_done  = mul_done;
        sts.div_done  = div_done;
        sts.sqrt_done = sqrt_done;
        sts.bail      = (acc_reg >> FRAC_BITS) > 64'(cfg.bailout_sq);
        sts.w3_zero   = (w3_reg == 64'sd0);
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/mde_ctrl.sv =====
// ----------------------------------------------------------------------------
// mde_ctrl
// Sequencer: steps each point through its fold iterations, then the root
// and the final division (skipped when w.w is zero), and loads the result.
// ----------------------------------------------------------------------------
module mde_ctrl
    import mde_pkg::*;
#(
    parameter int MAX_ITER = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic [4:0] iteration_count,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  mde_sts_t sts,
    output mde_cmd_t cmd
);

    localparam int IW = $clog2(MAX_ITER + 1);
    localparam int CW = (IW > 5) ? IW : 5;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FOLD  = 4'd1;
    localparam logic [3:0] S_SQ1   = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_MULF  = 4'd4;
    localparam logic [3:0] S_MULS  = 4'd5;
    localparam logic [3:0] S_TRAP  = 4'd6;
    localparam logic [3:0] S_SQ2   = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_DIV2  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next, limit, itv;
    logic          wait_reg, wait_next;
    logic          m_valid_reg, m_valid_next;

    always_comb begin
        itv = CW'(iteration_count);
        if (itv == '0) begin
            limit = CW'(1);
        end else if (itv > CW'(MAX_ITER)) begin
            limit = CW'(MAX_ITER);
        end else begin
            limit = itv;
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        wait_next    = wait_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_k    = k_reg;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold    = 1'b1;
                cmd.acc_clr = 1'b1;
                k_next      = 2'd0;
                state_next  = S_SQ1;
            end
            S_SQ1, S_SQ2, S_MULF, S_MULS: begin
                if (state_reg == S_MULF) begin
                    cmd.mul_b = MUL_B_F;
                end else if (state_reg == S_MULS) begin
                    cmd.mul_b = MUL_B_SCALE;
                end else begin
                    cmd.mul_b = MUL_B_SQ;
                end
                if (!wait_reg) begin
                    cmd.mul_start = 1'b1;
                    wait_next     = 1'b1;
                end else if (sts.mul_done) begin
                    wait_next = 1'b0;
                    k_next    = k_reg + 2'd1;
                    if ((state_reg == S_SQ1) && (k_reg == 2'd2)) begin
                        state_next = S_DIV1;
                    end else if ((state_reg == S_SQ2) && (k_reg == 2'd2)) begin
                        state_next = S_CHECK;
                    end else if ((state_reg == S_MULF) && (k_reg == 2'd3)) begin
                        k_next     = 2'd0;
                        state_next = S_MULS;
                    end else if ((state_reg == S_MULS) && (k_reg == 2'd3)) begin
                        state_next = S_TRAP;
                    end
                end
            end
            S_DIV1: begin
                cmd.div_sel = DIV_SEL_FOLD;
                if (!wait_reg) begin
                    cmd.div_start = 1'b1;
                    wait_next     = 1'b1;
                end else if (sts.div_done) begin
                    wait_next  = 1'b0;
                    k_next     = 2'd0;
                    state_next = S_MULF;
                end
            end
            S_TRAP: begin
                cmd.trap_upd = 1'b1;
                cmd.acc_clr  = 1'b1;
                k_next       = 2'd0;
                state_next   = S_SQ2;
            end
            S_CHECK: begin
                if (sts.bail || (cnt_reg + CW'(1) == limit)) begin
                    state_next = S_SQRT;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_FOLD;
                end
            end
            S_SQRT: begin
                if (!wait_reg) begin
                    cmd.sqrt_start = 1'b1;
                    wait_next      = 1'b1;
                end else if (sts.sqrt_done) begin
                    wait_next  = 1'b0;
                    state_next = S_DIV2;
                end
            end
            S_DIV2: begin
                cmd.div_sel = DIV_SEL_DIST;
                if (!wait_reg) begin
                    // zero derivative: skip the divide, distance saturates
                    if (sts.w3_zero) begin
                        state_next = S_OUT;
                    end else begin
                        cmd.div_start = 1'b1;
                        wait_next     = 1'b1;
                    end
                end else if (sts.div_done) begin
                    wait_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            cnt_reg     <= '0;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            cnt_reg     <= cnt_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/mandelbox_distance_estimator.sv =====
// ----------------------------------------------------------------------------
// mandelbox_distance_estimator
// Mandelbox distance estimate and orbit trap for one Q11.20 point.
//
//   channel   direction  ports                               payload
//   input     in         s_valid, s_ready, s_data            mde_in_t
//   result    out        m_valid, m_ready, m_data            mde_out_t
//   config    in         cfg_valid, cfg_ready, cfg_index,    register write
//                        cfg_data
//
// One point at a time. An iteration runs a divide for the sphere-fold factor
// and fourteen products on the shared 32x32 multiplier, each one or four
// passes. A point is accepted, runs its iterations, then a root, a divide
// (skipped when w.w is zero) and the output load. Reset is synchronous,
// active low, and restores the register defaults; a result waits in the
// output register while the next point runs.
// ----------------------------------------------------------------------------
module mandelbox_distance_estimator
    import mde_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int MAX_ITER  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mde_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mde_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [63:0] SCALE_MAG = (64'd5 << FRAC_BITS) >> 1;
    localparam logic [63:0] BAIL_FULL = 64'd1000 << FRAC_BITS;
    localparam logic [24:0] SCALE_RST = 25'(64'd0 - SCALE_MAG);
    localparam logic [23:0] MINR_RST  = 24'((64'd1 << FRAC_BITS) >> 2);
    localparam logic [23:0] FIXR_RST  = 24'(64'd1 << FRAC_BITS);
    localparam logic [23:0] BOX_RST   = 24'(64'd1 << FRAC_BITS);
    localparam logic [30:0] BAIL_RST  = (BAIL_FULL > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                   : 31'(BAIL_FULL);
    localparam logic [4:0]  ITER_RST  = 5'd10;

    mde_cfg_t cfg_reg;
    mde_cmd_t cmd;
    mde_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fold_scale      <= SCALE_RST;
            cfg_reg.min_radius_sq   <= MINR_RST;
            cfg_reg.fixed_radius_sq <= FIXR_RST;
            cfg_reg.box_limit       <= BOX_RST;
            cfg_reg.bailout_sq      <= BAIL_RST;
            cfg_reg.iteration_count <= ITER_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FOLD_SCALE:      cfg_reg.fold_scale      <= cfg_data[24:0];
                CFG_MIN_RADIUS_SQ:   cfg_reg.min_radius_sq   <= cfg_data[23:0];
                CFG_FIXED_RADIUS_SQ: cfg_reg.fixed_radius_sq <= cfg_data[23:0];
                CFG_BOX_LIMIT:       cfg_reg.box_limit       <= cfg_data[23:0];
                CFG_BAILOUT_SQ:      cfg_reg.bailout_sq      <= cfg_data[30:0];
                CFG_ITERATION_COUNT: cfg_reg.iteration_count <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    mde_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .iteration_count (cfg_reg.iteration_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .sts             (sts),
        .cmd             (cmd)
    );

    mde_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_data  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_data)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Mandelbox distance estimator. A local
// fixed-point model predicts distance and orbit trap for every accepted
// point; a monitor compares each result with the oldest prediction.
// Directed corner points and register settings come first, then random
// phases with random register settings, random idling and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import mde_pkg::*;

    localparam int  FRAC       = 20;
    localparam int  ITER_MAX   = 16;
    localparam int  STALL_LIMIT = 40000;
    localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LMIN = 64'sh8000_0000_0000_0000;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    mde_in_t         s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    mde_out_t        m_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mde_cfg_t  regs;
    mde_out_t  pending_q[$];
    int        errors = 0;
    int        results_seen = 0;
    bit        idle_on = 1'b1;
    logic      rx_hold = 1'b0;
    int        rx_wait = 0;
    int        stall_cnt = 0;

    mandelbox_distance_estimator #(.FRAC_BITS(FRAC), .MAX_ITER(ITER_MAX)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- fixed-point model ----------------
    function automatic longint sat32(longint a);
        if (a > 64'sd2147483647) return 64'sd2147483647;
        if (a < -64'sd2147483648) return -64'sd2147483648;
        return a;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        logic signed [64:0] t;
        t = $signed({a[63], a}) + $signed({b[63], b});
        if (t > $signed({1'b0, LMAX})) return LMAX;
        if (t < $signed({1'b1, LMIN})) return LMIN;
        return t[63:0];
    endfunction

    // product shifted down by FRAC, magnitude truncated, saturated
    function automatic longint mulq(longint a, longint b);
        logic [63:0]  x, y, m;
        logic [127:0] pr;
        bit           neg;
        x = (a < 0) ? -a : a;
        y = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        pr = {64'd0, x} * {64'd0, y};
        pr = pr >> FRAC;
        m = (pr[127:64] != 0) ? '1 : pr[63:0];
        if (neg) return (m >= 64'h8000_0000_0000_0000) ? LMIN : -$signed(m);
        return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? LMAX : $signed(m);
    endfunction

    function automatic longint unsigned sumsq(longint a, longint b, longint c);
        longint unsigned ma, mb, mc;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        return ma * ma + mb * mb + mc * mc;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic mde_out_t estimate(mde_in_t p);
        longint          w[4], w0[4], trap[4];
        longint          scale, lim, c;
        longint unsigned d, f, s, r, q, mw;
        int              iters;
        mde_out_t        o;
        scale = {{39{regs.fold_scale[24]}}, regs.fold_scale};
        lim   = {40'd0, regs.box_limit};
        iters = regs.iteration_count;
        if (iters < 1) iters = 1;
        if (iters > ITER_MAX) iters = ITER_MAX;
        w[0] = {{32{p.pos_x[31]}}, p.pos_x};
        w[1] = {{32{p.pos_y[31]}}, p.pos_y};
        w[2] = {{32{p.pos_z[31]}}, p.pos_z};
        w[3] = 64'sd1 <<< FRAC;
        for (int k = 0; k < 4; k++) begin
            w0[k] = w[k];
            trap[k] = w[k];
        end
        s = 0;
        for (int i = 0; i < iters; i++) begin
            for (int k = 0; k < 3; k++) begin
                c = w[k];
                if (c > lim) c = lim;
                if (c < -lim) c = -lim;
                w[k] = sat32(2 * c - w[k]);
            end
            d = sumsq(w[0], w[1], w[2]) >> FRAC;
            if (d < regs.min_radius_sq) d = regs.min_radius_sq;
            if (d > regs.fixed_radius_sq) d = regs.fixed_radius_sq;
            if (d == 0) d = 1;
            f = ({40'd0, regs.fixed_radius_sq} << FRAC) / d;
            for (int k = 0; k < 3; k++) w[k] = sat32(mulq(w[k], f));
            w[3] = mulq(w[3], f);
            for (int k = 0; k < 3; k++) w[k] = sat32(mulq(w[k], scale) + w0[k]);
            w[3] = sat_sum(mulq(w[3], scale), w0[3]);
            for (int k = 0; k < 4; k++) if (w[k] < trap[k]) trap[k] = w[k];
            s = sumsq(w[0], w[1], w[2]);
            if ((s >> FRAC) > regs.bailout_sq) break;
        end
        r = isqrt(s);
        if (w[3] == 0) begin
            q = DIST_MAX;
        end else begin
            mw = (w[3] < 0) ? -w[3] : w[3];
            q = ((r << FRAC) / mw) >> 2;
            if (q > DIST_MAX) q = DIST_MAX;
        end
        o.distance = q[30:0];
        o.trap_x   = trap[0][31:0];
        o.trap_y   = trap[1][31:0];
        o.trap_z   = trap[2][31:0];
        o.trap_w   = trap[3];
        return o;
    endfunction

    // ---------------- result monitor ----------------
    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        if (errors < 40)
            $display("MISMATCH result %0d %s: got %h want %h", results_seen, field, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        mde_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", m_data.distance, 0);
            end else begin
                want = pending_q.pop_front();
                if (m_data.distance != want.distance)
                    report("distance", m_data.distance, want.distance);
                if (m_data.trap_x != want.trap_x) report("trap_x", m_data.trap_x, want.trap_x);
                if (m_data.trap_y != want.trap_y) report("trap_y", m_data.trap_y, want.trap_y);
                if (m_data.trap_z != want.trap_z) report("trap_z", m_data.trap_z, want.trap_z);
                if (m_data.trap_w != want.trap_w) report("trap_w", m_data.trap_w, want.trap_w);
            end
            results_seen++;
        end
    end

    // receiver: random gap after each result while idle_on is set, held off while rx_hold is set
    always @(posedge aclk) begin
        int g;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (m_ready && m_valid) begin
            g = idle_on ? $urandom_range(0, 19) : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                rx_wait <= g - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("mandelbox_distance_estimator verification failed");
                $finish;
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_point(mde_in_t p);
        int g;
        g = idle_on ? $urandom_range(0, 19) : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(estimate(p));
    endtask

    // drop valid and hold until every expected result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] mask, data;
        case (idx)
            CFG_FOLD_SCALE:      mask = 32'h01FF_FFFF;
            CFG_BAILOUT_SQ:      mask = 32'h7FFF_FFFF;
            CFG_ITERATION_COUNT: mask = 32'h0000_001F;
            default:             mask = 32'h00FF_FFFF;
        endcase
        // junk in the unused upper bits must be dropped by the block
        data = ($urandom & ~mask) | (value & mask);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FOLD_SCALE:      regs.fold_scale      = data[24:0];
            CFG_MIN_RADIUS_SQ:   regs.min_radius_sq   = data[23:0];
            CFG_FIXED_RADIUS_SQ: regs.fixed_radius_sq = data[23:0];
            CFG_BOX_LIMIT:       regs.box_limit       = data[23:0];
            CFG_BAILOUT_SQ:      regs.bailout_sq      = data[30:0];
            CFG_ITERATION_COUNT: regs.iteration_count = data[4:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_all(int scale, int minr, int fixr, int box, int bail, int iters);
        cfg_write(CFG_FOLD_SCALE, scale);
        cfg_write(CFG_MIN_RADIUS_SQ, minr);
        cfg_write(CFG_FIXED_RADIUS_SQ, fixr);
        cfg_write(CFG_BOX_LIMIT, box);
        cfg_write(CFG_BAILOUT_SQ, bail);
        cfg_write(CFG_ITERATION_COUNT, iters);
    endtask

    function automatic mde_in_t pt(int x, int y, int z);
        mde_in_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        return p;
    endfunction

    function automatic mde_in_t rand_point();
        if ($urandom_range(0, 9) < 7)
            return pt($urandom_range(0, 6291456) - 3145728,
                      $urandom_range(0, 6291456) - 3145728,
                      $urandom_range(0, 6291456) - 3145728);
        return pt($urandom, $urandom, $urandom);
    endfunction

    // ---------------- tests ----------------
    task automatic test_defaults();
        send_point(pt(0, 0, 0));
        send_point(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_point(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_point(pt(1048576, -1048576, 524288));
        send_point(pt(1, -1, 1));
        send_point(pt(200000, 300000, -100000));
        send_point(pt(-1572864, 1572864, 2097152));
        drain();
    endtask

    // scale -1 with a large point makes w.w reach exactly zero
    task automatic test_zero_derivative();
        set_all(-1048576, 262144, 1048576, 1048576, 2147483647, 1);
        send_point(pt(32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
        send_point(pt(-536870912, 536870912, -536870912));
        drain();
    endtask

    task automatic test_radius_corners();
        // clamped radius of zero
        set_all(-2621440, 0, 0, 1048576, 1048576000, 3);
        send_point(pt(0, 0, 0));
        send_point(pt(100, -100, 50));
        drain();
        // inverted radii with a zero box limit, then a large box limit
        set_all(8388608, 8388608, 1, 0, 1048576000, 2);
        send_point(pt(300000, 200000, 100000));
        drain();
        set_all(-8388608, 1, 8388608, 8388608, 0, 2);
        send_point(pt(300000, -700000, 900000));
        send_point(pt(-9000000, 9000000, 1));
        drain();
    endtask

    task automatic test_iteration_bounds();
        set_all(-2621440, 262144, 1048576, 1048576, 2147483647, 0);
        send_point(pt(500000, 400000, -300000));
        drain();
        cfg_write(CFG_ITERATION_COUNT, 16);
        send_point(pt(100000, -200000, 50000));
        drain();
        cfg_write(CFG_ITERATION_COUNT, 17);
        send_point(pt(-100000, 200000, 50000));
        drain();
        cfg_write(CFG_ITERATION_COUNT, 31);
        send_point(pt(10000, 20000, -30000));
        drain();
    endtask

    task automatic test_random_phases();
        int scale, minr, fixr, bail, iters;
        for (int ph = 0; ph < 10; ph++) begin
            idle_on = (ph % 4) != 2;
            scale = ($urandom_range(0, 4) == 0) ? $urandom
                                                 : $urandom_range(0, 7340032) - 3670016;
            minr  = $urandom_range(1, 1048576);
            fixr  = $urandom_range(1, 4194304);
            bail  = $urandom_range(0, 1) ? $urandom_range(0, 2147483647)
                                         : $urandom_range(0, 104857600);
            iters = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
                                                 : $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) begin
                minr = $urandom;
                fixr = $urandom;
            end
            set_all(scale, minr, fixr, $urandom_range(0, 3145728), bail, iters);
            repeat (60) send_point(rand_point());
            drain();
        end
        idle_on = 1'b1;
    endtask

    // receiver stalls while points keep coming; then sender waits for all
    task automatic test_backpressure();
        set_all(-2621440, 262144, 1048576, 1048576, 1048576000, 2);
        idle_on = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (4000) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (10) send_point(rand_point());
        drain();
        idle_on = 1'b1;
    endtask

    initial begin
        regs.fold_scale      = 25'h1D8_0000;
        regs.min_radius_sq   = 24'd262144;
        regs.fixed_radius_sq = 24'd1048576;
        regs.box_limit       = 24'd1048576;
        regs.bailout_sq      = 31'd1048576000;
        regs.iteration_count = 5'd10;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults();
        test_zero_derivative();
        test_radius_corners();
        test_iteration_bounds();
        test_random_phases();
        test_backpressure();

        repeat (300) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("mandelbox_distance_estimator verification clean");
        end else begin
            $display("mandelbox_distance_estimator verification failed");
        end
        $finish;
    end

endmodule
